// ===== rtl/core/bounding_box_overlay_assert.svh =====
// assertion macros for the bounding box overlay block
// used by the top level only, no other dependencies
`ifndef BOUNDING_BOX_OVERLAY_ASSERT_SVH
`define BOUNDING_BOX_OVERLAY_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define BBO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define BBO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bbo_pkg.sv =====
// shared types and constants of the bounding box overlay
// no dependencies
package bbo_pkg;

  localparam int MaxBoxes  = 16;
  localparam int CoordBits = 12;
  localparam int SlotBits  = 4;
  localparam int PixBits   = 8;
  localparam int PlaneBits = 2;
  localparam int OpBits    = 2;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 8;

  localparam int InDataBits  = 88;
  localparam int InUserBits  = OpBits + PlaneBits;
  localparam int OutDataBits = PixBits;

  localparam int CellIdxBits = ($clog2(MaxBoxes) > SlotBits) ? $clog2(MaxBoxes) : SlotBits;

  typedef enum logic [OpBits-1:0] {
    OpLoad  = 2'd0,
    OpClear = 2'd1,
    OpPixel = 2'd2
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLayout = 2'd0,
    CfgLuma   = 2'd1,
    CfgCb     = 2'd2,
    CfgCr     = 2'd3
  } cfg_idx_e;

  localparam logic [PlaneBits-1:0] PlaneY = 2'd0;
  localparam logic [PlaneBits-1:0] PlaneU = 2'd1;
  localparam logic [PlaneBits-1:0] PlaneV = 2'd2;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [CoordBits:0]   coord_ext_t;

  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic [SlotBits-1:0]  slot;
    coord_t               x;
    coord_t               y;
    coord_t               w;
    coord_t               h;
    logic [PlaneBits-1:0] plane;
    coord_t               col;
    coord_t               row;
    logic [PixBits-1:0]   pix;
    logic                 hit;
  } item_t;

  typedef struct packed {
    logic [PixBits-1:0] pix;
    logic               border;
  } result_t;

endpackage

// ===== rtl/core/bbo_cell.sv =====
// one chain cell: holds one box slot and tests the passing pixel against it
// depends on bbo_pkg
module bbo_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [bbo_pkg::CellIdxBits-1:0]  idx_i,
  input  logic                             planar_i,
  input  bbo_pkg::item_t                   item_i,
  output bbo_pkg::item_t                   item_o
);

  localparam int Cb = bbo_pkg::CoordBits;

  logic                   box_vld_q;
  bbo_pkg::coord_t        bx_q, by_q;
  bbo_pkg::coord_ext_t    bxe_q, bye_q;
  bbo_pkg::coord_t        ex_x, ex_y;
  bbo_pkg::item_t         item_q, item_d;
  logic                   vld_q;

  logic                   is_load, is_clear, is_pix;
  bbo_pkg::coord_t        c, r, c_half, r_half, bx_half, by_half, bxe_half, bye_half;
  bbo_pkg::coord_ext_t    c_e, r_e;
  logic                   l_in, l_edge, c_in, c_edge;
  logic                   side_b, span_b, side_p, span_p;
  logic                   hit_here;

  assign is_pix   = item_i.valid && (item_i.op == bbo_pkg::OpPixel);
  assign is_clear = item_i.valid && (item_i.op == bbo_pkg::OpClear);
  assign is_load  = item_i.valid && (item_i.op == bbo_pkg::OpLoad) &&
                    (bbo_pkg::CellIdxBits'(item_i.slot) == idx_i);

  // corners and sizes are stored rounded down to even
  assign ex_x = {item_i.x[Cb-1:1], 1'b0};
  assign ex_y = {item_i.y[Cb-1:1], 1'b0};

  assign c        = item_i.col;
  assign r        = item_i.row;
  assign c_e      = {1'b0, c};
  assign r_e      = {1'b0, r};
  assign c_half   = c >> 1;
  assign r_half   = r >> 1;
  assign bx_half  = bx_q >> 1;
  assign by_half  = by_q >> 1;
  assign bxe_half = bxe_q[Cb:1];
  assign bye_half = bye_q[Cb:1];

  // luma rows: y .. y+h-1, edge rows y, y+1 at top and y+h-2, y+h-1 at bottom
  assign l_in   = (r_e >= {1'b0, by_q}) && (r_e < bye_q);
  assign l_edge = (r_half == by_half) || (({1'b0, r_half} + 1'b1) == {1'b0, bye_half});

  // chroma rows: y/2 .. (y+h)/2-1, one edge row at top and bottom
  assign c_in   = (r >= by_half) && (r < bye_half);
  assign c_edge = (r == by_half) || ((r_e + 1'b1) == {1'b0, bye_half});

  // byte columns, shared by luma and interleaved chroma
  assign side_b = (c_half == bx_half) || (c_half == bxe_half);
  assign span_b = (c_e >= {1'b0, bx_q}) && (c_e < bxe_q);

  // planar chroma columns
  assign side_p = (c == bx_half) || (c == bxe_half);
  assign span_p = (c >= bx_half) && (c < bxe_half);

  always_comb begin
    hit_here = 1'b0;
    case (item_i.plane)
      bbo_pkg::PlaneY: begin
        hit_here = l_in && (side_b || (l_edge && span_b));
      end
      bbo_pkg::PlaneU: begin
        if (planar_i) begin
          hit_here = c_in && (side_p || (c_edge && span_p));
        end else begin
          hit_here = c_in && (side_b || (c_edge && span_b));
        end
      end
      bbo_pkg::PlaneV: begin
        hit_here = planar_i && c_in && (side_p || (c_edge && span_p));
      end
      default: begin
        hit_here = 1'b0;
      end
    endcase
    hit_here = hit_here && box_vld_q && is_pix;
  end

  always_comb begin
    item_d     = item_i;
    item_d.hit = item_i.hit || hit_here;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_vld_q <= 1'b0;
      vld_q     <= 1'b0;
    end else if (en_i) begin
      vld_q <= item_i.valid;
      if (is_clear) begin
        box_vld_q <= 1'b0;
      end else if (is_load) begin
        box_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
      if (is_load) begin
        bx_q  <= ex_x;
        by_q  <= ex_y;
        bxe_q <= {1'b0, ex_x} + {1'b0, item_i.w[Cb-1:1], 1'b0};
        bye_q <= {1'b0, ex_y} + {1'b0, item_i.h[Cb-1:1], 1'b0};
      end
    end
  end

  always_comb begin
    item_o       = item_q;
    item_o.valid = vld_q;
  end

endmodule

// ===== rtl/core/bbo_obuf.sv =====
// two-entry output buffer that decouples the cell chain from the result stream
// depends on bbo_pkg
module bbo_obuf (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  bbo_pkg::result_t                   data_i,
  output logic                               ready_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bbo_pkg::OutDataBits-1:0]    m_axis_tdata,  // pixel_out
  output logic                               m_axis_tuser   // on_border
);

  bbo_pkg::result_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign ready_o       = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = mem_q[rd_ptr_q].pix;
  assign m_axis_tuser  = mem_q[rd_ptr_q].border;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/bounding_box_overlay.sv =====
// Bounding box border overlay for a YUV 4:2:0 sample stream. Each item runs
// through a row of MAX_BOXES cells, one box slot per cell, one cell per clock
// while the chain advances, then into a two-entry output buffer. One item is
// taken every clock as long as the buffer has room; a pixel result passes every
// cell register before it enters the buffer. Loads and clears ride the same row,
// so every item sees exactly the table left by the items before it. There is no
// clearing pass: reset clears the per-cell valid bits at once.
// depends on bbo_pkg, bbo_cell, bbo_obuf and bounding_box_overlay_assert.svh
`include "bounding_box_overlay_assert.svh"

module bounding_box_overlay (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [bbo_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [bbo_pkg::CfgDataBits-1:0]      cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // slot, box_left, box_top, box_width, box_height, col, row, pixel_in, 4 zero bits
  input  logic [bbo_pkg::InDataBits-1:0]       s_axis_tdata,
  // op, plane
  input  logic [bbo_pkg::InUserBits-1:0]       s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bbo_pkg::OutDataBits-1:0]      m_axis_tdata,  // pixel_out
  output logic                                 m_axis_tuser   // on_border
);

  localparam int N  = bbo_pkg::MaxBoxes;

  logic                        planar_q;
  logic [bbo_pkg::PixBits-1:0] luma_q, cb_q, cr_q;

  bbo_pkg::item_t   chain [N+1];
  bbo_pkg::item_t   last;
  bbo_pkg::result_t res;
  logic             advance, s_fire, push;
  logic [bbo_pkg::PixBits-1:0] color;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planar_q <= 1'b0;
      luma_q   <= 8'd0;
      cb_q     <= 8'd128;
      cr_q     <= 8'd128;
    end else if (cfg_we_i) begin
      case (bbo_pkg::cfg_idx_e'(cfg_idx_i))
        bbo_pkg::CfgLayout: planar_q <= ~cfg_data_i[0];
        bbo_pkg::CfgLuma:   luma_q   <= cfg_data_i;
        bbo_pkg::CfgCb:     cb_q     <= cfg_data_i;
        bbo_pkg::CfgCr:     cr_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = advance;
  assign s_fire        = s_axis_tvalid && advance;

  // unpack the transfer into the head of the chain
  always_comb begin
    chain[0].valid = s_fire;
    chain[0].op    = bbo_pkg::op_e'(s_axis_tuser[1:0]);
    chain[0].plane = s_axis_tuser[3:2];
    chain[0].slot  = s_axis_tdata[3:0];
    chain[0].x     = s_axis_tdata[15:4];
    chain[0].y     = s_axis_tdata[27:16];
    chain[0].w     = s_axis_tdata[39:28];
    chain[0].h     = s_axis_tdata[51:40];
    chain[0].col   = s_axis_tdata[63:52];
    chain[0].row   = s_axis_tdata[75:64];
    chain[0].pix   = s_axis_tdata[83:76];
    chain[0].hit   = 1'b0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    bbo_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (advance),
      .idx_i    (bbo_pkg::CellIdxBits'(i)),
      .planar_i (planar_q),
      .item_i   (chain[i]),
      .item_o   (chain[i+1])
    );
  end

  assign last = chain[N];
  assign push = advance && last.valid && (last.op == bbo_pkg::OpPixel);

  always_comb begin
    case (last.plane)
      bbo_pkg::PlaneY: color = luma_q;
      bbo_pkg::PlaneU: color = planar_q ? cb_q : (last.col[0] ? cr_q : cb_q);
      bbo_pkg::PlaneV: color = planar_q ? cr_q : (last.col[0] ? cr_q : cb_q);
      default:         color = last.pix;
    endcase
    res.pix    = last.hit ? color : last.pix;
    res.border = last.hit;
  end

  bbo_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_i        (res),
    .ready_o       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  `BBO_ASSERT_IMP(a_stall_means_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid, "chain stalled without a waiting result")
  `BBO_ASSERT_IMP(a_hit_only_on_pixel, clk_i, rst_ni, last.valid && last.hit, last.op == bbo_pkg::OpPixel, "border hit on a non-pixel item")
  `BBO_ASSERT_NXT(a_head_cell_takes, clk_i, rst_ni, s_fire, chain[1].valid, "accepted transfer missing from first cell")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for bounding_box_overlay: box loads, clears and yuv 4:2:0
// samples stream in and every result is checked against an in-bench overlay model
// depends on bbo_pkg and the bounding_box_overlay rtl
module tb_top;

  localparam int unsigned CycleLimit  = 400000;
  localparam int          DrainCycles = 40;
  localparam int          PhaseItems  = 205;
  localparam int          HoldCycles  = 300;
  localparam int          Frame       = 48;

  localparam logic [bbo_pkg::OpBits-1:0]    OpUnused  = 2'd3;
  localparam logic [bbo_pkg::PlaneBits-1:0] PlaneNone = 2'd3;

  typedef struct {
    logic [bbo_pkg::OpBits-1:0]    op;
    logic [bbo_pkg::SlotBits-1:0]  slot;
    bbo_pkg::coord_t               x;
    bbo_pkg::coord_t               y;
    bbo_pkg::coord_t               w;
    bbo_pkg::coord_t               h;
    logic [bbo_pkg::PlaneBits-1:0] plane;
    bbo_pkg::coord_t               col;
    bbo_pkg::coord_t               row;
    logic [bbo_pkg::PixBits-1:0]   pix;
  } stim_t;

  typedef struct {
    logic [bbo_pkg::PixBits-1:0] pix;
    logic                        border;
  } overlay_t;

  typedef struct {
    logic        lit;
    int unsigned x, y, w, h;
  } box_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [bbo_pkg::CfgIdxBits-1:0]  cfg_idx_i     = '0;
  logic [bbo_pkg::CfgDataBits-1:0] cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bbo_pkg::InDataBits-1:0]  s_axis_tdata  = '0;
  logic [bbo_pkg::InUserBits-1:0]  s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bbo_pkg::OutDataBits-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  bounding_box_overlay u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state: box table and color registers
  box_t        boxes [bbo_pkg::MaxBoxes];
  logic        layout_ilv = 1'b1;
  logic [7:0]  luma_color = 8'd0;
  logic [7:0]  cb_color   = 8'd128;
  logic [7:0]  cr_color   = 8'd128;

  stim_t       pending_items [$];
  overlay_t    expected_pixels [$];
  overlay_t    want;

  stim_t       tx_item;
  bit          tx_busy, tx_done, rx_done, hold_req;
  int          tx_gap, rx_gap, hold_left, tx_mode, rx_mode;
  int unsigned cycles;
  int          errors, n_checked, n_loads, n_clears, n_ignored;

  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // applies one accepted item to the model and queues the sample a pixel item produces
  function automatic void overlay_step(stim_t s);
    int unsigned c, r, bx, by, bw, bh, top, bot, cx, cw;
    logic        planar, usable, hit, side, edge_row;
    logic [7:0]  color;
    planar = !layout_ilv;
    hit    = 1'b0;
    case (s.op)
      bbo_pkg::OpLoad: begin
        boxes[s.slot].lit = 1'b1;
        boxes[s.slot].x   = 32'({s.x[bbo_pkg::CoordBits-1:1], 1'b0});
        boxes[s.slot].y   = 32'({s.y[bbo_pkg::CoordBits-1:1], 1'b0});
        boxes[s.slot].w   = 32'({s.w[bbo_pkg::CoordBits-1:1], 1'b0});
        boxes[s.slot].h   = 32'({s.h[bbo_pkg::CoordBits-1:1], 1'b0});
        n_loads++;
      end
      bbo_pkg::OpClear: begin
        foreach (boxes[i]) boxes[i].lit = 1'b0;
        n_clears++;
      end
      bbo_pkg::OpPixel: begin
        c = 32'(s.col);
        r = 32'(s.row);
        usable = (s.plane == bbo_pkg::PlaneY) || (s.plane == bbo_pkg::PlaneU) ||
                 (s.plane == bbo_pkg::PlaneV && planar);
        if (s.plane == bbo_pkg::PlaneY) color = luma_color;
        else if (!planar) color = s.col[0] ? cr_color : cb_color;
        else color = (s.plane == bbo_pkg::PlaneU) ? cb_color : cr_color;
        for (int i = 0; i < bbo_pkg::MaxBoxes; i++) begin
          if (usable && !hit && boxes[i].lit) begin
            bx = boxes[i].x;
            by = boxes[i].y;
            bw = boxes[i].w;
            bh = boxes[i].h;
            side = (c == bx) || (c == bx + 1) || (c == bx + bw) || (c == bx + bw + 1);
            if (s.plane == bbo_pkg::PlaneY) begin
              if (r >= by && r < by + bh)
                hit = side || ((r == by || r == by + 1 || r + 1 == by + bh || r + 2 == by + bh)
                               && c >= bx && c < bx + bw);
            end else begin
              // chroma rows are half rows, one line at top and bottom
              top = by >> 1;
              bot = (by + bh) >> 1;
              if (r >= top && r < bot) begin
                edge_row = (r == top) || (r + 1 == bot);
                if (planar) begin
                  cx  = bx >> 1;
                  cw  = bw >> 1;
                  hit = (c == cx) || (c == cx + cw) || (edge_row && c >= cx && c < cx + cw);
                end else begin
                  hit = side || (edge_row && c >= bx && c < bx + bw);
                end
              end
            end
          end
        end
        expected_pixels.push_back('{hit ? color : s.pix, hit});
      end
      default: n_ignored++;
    endcase
  endfunction

  // every field random, callers overwrite what matters
  function automatic stim_t junk_item(logic [bbo_pkg::OpBits-1:0] op);
    stim_t s;
    s.op    = op;
    s.slot  = bbo_pkg::SlotBits'($urandom);
    s.x     = bbo_pkg::coord_t'($urandom);
    s.y     = bbo_pkg::coord_t'($urandom);
    s.w     = bbo_pkg::coord_t'($urandom);
    s.h     = bbo_pkg::coord_t'($urandom);
    s.plane = bbo_pkg::PlaneBits'($urandom);
    s.col   = bbo_pkg::coord_t'($urandom);
    s.row   = bbo_pkg::coord_t'($urandom);
    s.pix   = bbo_pkg::PixBits'($urandom);
    return s;
  endfunction

  function automatic void add_load(logic [bbo_pkg::SlotBits-1:0] slot, bbo_pkg::coord_t x,
                                   bbo_pkg::coord_t y, bbo_pkg::coord_t w,
                                   bbo_pkg::coord_t h);
    stim_t s;
    s      = junk_item(bbo_pkg::OpLoad);
    s.slot = slot;
    s.x    = x;
    s.y    = y;
    s.w    = w;
    s.h    = h;
    pending_items.push_back(s);
  endfunction

  function automatic void add_pixel(logic [bbo_pkg::PlaneBits-1:0] plane, bbo_pkg::coord_t col,
                                    bbo_pkg::coord_t row, logic [bbo_pkg::PixBits-1:0] pix);
    stim_t s;
    s       = junk_item(bbo_pkg::OpPixel);
    s.plane = plane;
    s.col   = col;
    s.row   = row;
    s.pix   = pix;
    pending_items.push_back(s);
  endfunction

  // mostly small boxes inside a small frame, a few over the full range
  function automatic void add_random_load();
    bit wide;
    wide = ($urandom_range(0, 9) == 0);
    add_load(bbo_pkg::SlotBits'($urandom),
             bbo_pkg::coord_t'(wide ? $urandom_range(0, 4095) : $urandom_range(0, Frame)),
             bbo_pkg::coord_t'(wide ? $urandom_range(0, 4095) : $urandom_range(0, Frame)),
             bbo_pkg::coord_t'(wide ? $urandom_range(0, 4095) : $urandom_range(0, Frame / 2)),
             bbo_pkg::coord_t'(wide ? $urandom_range(0, 4095) : $urandom_range(0, Frame / 2)));
  endfunction

  function automatic void add_random_phase(int count);
    int k;
    pending_items.push_back(junk_item(bbo_pkg::OpClear));
    repeat ($urandom_range(2, 6)) add_random_load();
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (k < 2) begin
        pending_items.push_back(junk_item(bbo_pkg::OpClear));
      end else if (k < 4) begin
        pending_items.push_back(junk_item(OpUnused));
      end else if (k < 14) begin
        add_random_load();
      end else if ($urandom_range(0, 9) == 0) begin
        add_pixel(bbo_pkg::PlaneBits'($urandom), bbo_pkg::coord_t'($urandom),
                  bbo_pkg::coord_t'($urandom), bbo_pkg::PixBits'($urandom));
      end else begin
        add_pixel(($urandom_range(0, 15) == 0) ? PlaneNone
                                               : bbo_pkg::PlaneBits'($urandom_range(0, 2)),
                  bbo_pkg::coord_t'($urandom_range(0, Frame + 3)),
                  bbo_pkg::coord_t'($urandom_range(0, Frame + 3)),
                  bbo_pkg::PixBits'($urandom));
      end
    end
  endfunction

  task automatic write_reg(bbo_pkg::cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic set_regs(logic layout, logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
    write_reg(bbo_pkg::CfgLayout, {7'd0, layout});
    write_reg(bbo_pkg::CfgLuma, luma);
    write_reg(bbo_pkg::CfgCb, cb);
    write_reg(bbo_pkg::CfgCr, cr);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    layout_ilv = layout;
    luma_color = luma;
    cb_color   = cb;
    cr_color   = cr;
  endtask

  // loads and clears give no result, so let the pipe empty after the last sample
  task automatic drain();
    while (pending_items.size() > 0 || tx_busy || expected_pixels.size() > 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // input side: one transfer per item, random gap before the next
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tx_done) begin
        tx_done = 1'b0;
        tx_busy = 1'b0;
      end
      if (!tx_busy && pending_items.size() > 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else begin
          tx_item = pending_items.pop_front();
          tx_busy = 1'b1;
          tx_gap  = draw_wait(tx_mode);
        end
      end
      s_axis_tvalid <= tx_busy;
      s_axis_tdata  <= {4'd0, tx_item.pix, tx_item.row, tx_item.col, tx_item.h, tx_item.w,
                        tx_item.y, tx_item.x, tx_item.slot};
      s_axis_tuser  <= {tx_item.plane, tx_item.op};
    end
  end

  // output side: random stall after every transfer, plus the long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_done) begin
        rx_done = 1'b0;
        rx_gap  = draw_wait(rx_mode);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        overlay_step(tx_item);
        tx_done = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        rx_done = 1'b1;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result pix %02h border %0b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_pixels.pop_front();
          n_checked++;
          if (m_axis_tdata !== want.pix || m_axis_tuser !== want.border) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected pix %02h border %0b, got pix %02h border %0b",
                       n_checked, want.pix, want.border, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_pixels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    foreach (boxes[i]) boxes[i] = '{1'b0, 0, 0, 0, 0};
    tx_item = junk_item(bbo_pkg::OpClear);
    tx_mode = 2;
    rx_mode = 2;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset register values (interleaved chroma)
    pending_items.push_back(junk_item(bbo_pkg::OpClear));
    add_load(4'd0, 12'd5, 12'd5, 12'd9, 12'd9);               // odd values round down
    add_load(4'd15, 12'hfff, 12'hfff, 12'hfff, 12'hfff);      // box at the far corner
    add_load(4'd3, 12'd20, 12'd20, 12'd10, 12'd0);            // zero height
    add_load(4'd7, 12'd40, 12'd2, 12'd0, 12'd6);              // zero width
    pending_items.push_back(junk_item(OpUnused));
    add_pixel(bbo_pkg::PlaneY, 12'd4, 12'd4, 8'hff);
    add_pixel(bbo_pkg::PlaneY, 12'd12, 12'd8, 8'h00);
    add_pixel(bbo_pkg::PlaneY, 12'd8, 12'd7, 8'h5a);
    add_pixel(bbo_pkg::PlaneY, 12'd11, 12'd10, 8'ha5);
    add_pixel(bbo_pkg::PlaneY, 12'd4094, 12'd4094, 8'h11);
    add_pixel(bbo_pkg::PlaneY, 12'd4095, 12'd4095, 8'hee);
    add_pixel(bbo_pkg::PlaneY, 12'd0, 12'd0, 8'h00);
    add_pixel(bbo_pkg::PlaneY, 12'd20, 12'd20, 8'h77);
    add_pixel(bbo_pkg::PlaneY, 12'd41, 12'd7, 8'h33);
    add_pixel(bbo_pkg::PlaneU, 12'd5, 12'd2, 8'h12);
    add_pixel(bbo_pkg::PlaneU, 12'd8, 12'd5, 8'h34);
    add_pixel(bbo_pkg::PlaneU, 12'd8, 12'd3, 8'h56);
    add_pixel(bbo_pkg::PlaneV, 12'd4, 12'd2, 8'h78);          // no v plane when interleaved
    add_pixel(PlaneNone, 12'd4, 12'd4, 8'h9a);
    add_pixel(bbo_pkg::PlaneU, 12'd4095, 12'd2047, 8'hbc);
    pending_items.push_back(junk_item(bbo_pkg::OpClear));
    add_pixel(bbo_pkg::PlaneY, 12'd4, 12'd4, 8'hde);

    for (int p = 1; p <= 6; p++) begin
      drain();
      case (p)
        1:       set_regs(1'b0, 8'hff, 8'h00, 8'hff);
        2:       set_regs(1'b1, 8'h00, 8'hff, 8'h00);
        3:       set_regs(1'b0, 8'h00, 8'h00, 8'h00);
        default: set_regs(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      tx_mode = (p == 2) ? 0 : p % 3;
      rx_mode = (p + 1) % 3;
      // back-to-back input while the output is held off fills the pipe
      if (p == 2) hold_req = 1'b1;
      add_random_phase(PhaseItems);
    end
    drain();

    $display("checked %0d samples; %0d box loads, %0d clears, %0d ignored ops",
             n_checked, n_loads, n_clears, n_ignored);
    $display("six register settings in both chroma layouts, with gaps, stalls and a hold-off");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
